>>> hw/rtl/ldga_pkg.sv
// Shared types, constants and the 5x7 dot glyph table for the LED dot-matrix
// glyph atlas raster generator. No dependencies.
package ldga_pkg;

  localparam int GLYPH_COUNT_DEF  = 76;
  localparam int CELLS_ACROSS_DEF = 8;
  localparam int CELLS_DOWN_DEF   = 12;

  localparam int ROM_SLOTS   = 96;
  localparam int ROM_AW      = $clog2(ROM_SLOTS);
  localparam int CELL_IDX_W  = 8;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int DOT_BITS    = GLYPH_COLS * GLYPH_ROWS;
  localparam int DOT_BIT_W   = $clog2(DOT_BITS);
  localparam int CODE_W      = 7;
  localparam int POS_X_W     = 11;
  localparam int POS_Y_W     = 12;
  localparam int IN_CELL_W   = 8;
  localparam int DOT_IDX_W   = 3;
  localparam int DOT_POS_W   = 5;
  localparam int CFG_W       = 4;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  // register indexes, decoded from paddr[2]
  localparam logic REG_DOT_SIZE   = 1'b0;
  localparam logic REG_DOT_MARGIN = 1'b1;

  // dots: row 0 in the top five bits, leftmost dot is the MSB of each row
  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [DOT_BITS-1:0] dots;
  } glyph_t;

  function automatic glyph_t glyph_entry(input logic [ROM_AW-1:0] addr);
    logic [CODE_W+DOT_BITS-1:0] e;
    case (addr)
      7'd0:  e = {7'h41, 5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      7'd1:  e = {7'h42, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      7'd2:  e = {7'h43, 5'h0E, 5'h11, 5'h11, 5'h10, 5'h11, 5'h11, 5'h0E};
      7'd3:  e = {7'h44, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      7'd4:  e = {7'h45, 5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      7'd5:  e = {7'h46, 5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      7'd6:  e = {7'h47, 5'h0E, 5'h11, 5'h11, 5'h10, 5'h17, 5'h11, 5'h0E};
      7'd7:  e = {7'h48, 5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      7'd8:  e = {7'h49, 5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'd9:  e = {7'h4A, 5'h03, 5'h01, 5'h01, 5'h01, 5'h11, 5'h11, 5'h0E};
      7'd10: e = {7'h4B, 5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      7'd11: e = {7'h4C, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      7'd12: e = {7'h4D, 5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      7'd13: e = {7'h4E, 5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11};
      7'd14: e = {7'h4F, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'd15: e = {7'h50, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      7'd16: e = {7'h51, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h13, 5'h0F};
      7'd17: e = {7'h52, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      7'd18: e = {7'h53, 5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
      7'd19: e = {7'h54, 5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      7'd20: e = {7'h55, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      7'd21: e = {7'h56, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      7'd22: e = {7'h57, 5'h11, 5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A};
      7'd23: e = {7'h58, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      7'd24: e = {7'h59, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      7'd25: e = {7'h5A, 5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      7'd26: e = {7'h30, 5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      7'd27: e = {7'h31, 5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
      7'd28: e = {7'h32, 5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      7'd29: e = {7'h33, 5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E};
      7'd30: e = {7'h34, 5'h03, 5'h05, 5'h09, 5'h11, 5'h1F, 5'h01, 5'h01};
      7'd31: e = {7'h35, 5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      7'd32: e = {7'h36, 5'h0E, 5'h11, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      7'd33: e = {7'h37, 5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h04, 5'h04};
      7'd34: e = {7'h38, 5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      7'd35: e = {7'h39, 5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E};
      7'd36: e = {7'h61, 5'h00, 5'h00, 5'h0C, 5'h12, 5'h12, 5'h12, 5'h0D};
      7'd37: e = {7'h62, 5'h00, 5'h10, 5'h10, 5'h1C, 5'h12, 5'h12, 5'h1C};
      7'd38: e = {7'h63, 5'h00, 5'h00, 5'h0C, 5'h12, 5'h10, 5'h12, 5'h0C};
      7'd39: e = {7'h64, 5'h00, 5'h02, 5'h02, 5'h0E, 5'h12, 5'h12, 5'h0E};
      7'd40: e = {7'h65, 5'h00, 5'h00, 5'h0C, 5'h12, 5'h1E, 5'h10, 5'h0E};
      7'd41: e = {7'h66, 5'h00, 5'h0C, 5'h10, 5'h10, 5'h1C, 5'h10, 5'h10};
      7'd42: e = {7'h67, 5'h00, 5'h0C, 5'h12, 5'h12, 5'h0E, 5'h02, 5'h0C};
      7'd43: e = {7'h68, 5'h00, 5'h10, 5'h10, 5'h1C, 5'h12, 5'h12, 5'h12};
      7'd44: e = {7'h69, 5'h00, 5'h10, 5'h00, 5'h10, 5'h10, 5'h10, 5'h10};
      7'd45: e = {7'h6A, 5'h02, 5'h00, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
      7'd46: e = {7'h6B, 5'h00, 5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12};
      7'd47: e = {7'h6C, 5'h00, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10};
      7'd48: e = {7'h6D, 5'h00, 5'h00, 5'h0A, 5'h15, 5'h15, 5'h11, 5'h11};
      7'd49: e = {7'h6E, 5'h00, 5'h00, 5'h14, 5'h1A, 5'h12, 5'h12, 5'h12};
      7'd50: e = {7'h6F, 5'h00, 5'h00, 5'h0C, 5'h12, 5'h12, 5'h12, 5'h0C};
      7'd51: e = {7'h70, 5'h00, 5'h1C, 5'h12, 5'h12, 5'h1C, 5'h10, 5'h10};
      7'd52: e = {7'h71, 5'h00, 5'h0E, 5'h12, 5'h12, 5'h0E, 5'h02, 5'h02};
      7'd53: e = {7'h72, 5'h00, 5'h00, 5'h16, 5'h18, 5'h10, 5'h10, 5'h10};
      7'd54: e = {7'h73, 5'h00, 5'h00, 5'h0E, 5'h10, 5'h0C, 5'h02, 5'h1C};
      7'd55: e = {7'h74, 5'h00, 5'h10, 5'h10, 5'h1C, 5'h10, 5'h10, 5'h0C};
      7'd56: e = {7'h75, 5'h00, 5'h00, 5'h12, 5'h12, 5'h12, 5'h12, 5'h0C};
      7'd57: e = {7'h76, 5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      7'd58: e = {7'h77, 5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h15, 5'h0A};
      7'd59: e = {7'h78, 5'h00, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11};
      7'd60: e = {7'h79, 5'h00, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      7'd61: e = {7'h7A, 5'h00, 5'h00, 5'h1F, 5'h02, 5'h04, 5'h08, 5'h1F};
      7'd62: e = {7'h2E, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04};
      7'd63: e = {7'h2C, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
      7'd64: e = {7'h3A, 5'h00, 5'h00, 5'h04, 5'h00, 5'h00, 5'h04, 5'h00};
      7'd65: e = {7'h2D, 5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
      7'd66: e = {7'h2B, 5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
      7'd67: e = {7'h2A, 5'h00, 5'h00, 5'h0A, 5'h04, 5'h0A, 5'h00, 5'h00};
      7'd68: e = {7'h2F, 5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
      7'd69: e = {7'h3C, 5'h00, 5'h04, 5'h08, 5'h10, 5'h08, 5'h04, 5'h00};
      7'd70: e = {7'h3E, 5'h00, 5'h10, 5'h08, 5'h04, 5'h08, 5'h10, 5'h00};
      7'd71: e = {7'h28, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
      7'd72: e = {7'h29, 5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
      7'd73: e = {7'h21, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h00, 5'h10};
      7'd74: e = {7'h3F, 5'h0C, 5'h12, 5'h02, 5'h04, 5'h08, 5'h00, 5'h08};
      7'd75: e = {7'h20, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00};
      default: e = '0;
    endcase
    return glyph_t'(e);
  endfunction

endpackage

>>> hw/rtl/led_dot_matrix_glyph_atlas_unit.sv
// LED dot-matrix glyph atlas raster generator, top level.
// Depends on ldga_pkg and ldga_glyph_rom.
//
// Every transfer with in_pixel_tick high yields the next atlas pixel in raster order,
// one pixel per clock sustained while out_stall is low; a transfer with in_pixel_tick
// low yields nothing. The glyph ROM read is registered and feeds the output register,
// which also lets a new pixel enter while a finished one waits on out_stall.
// Position is kept by counters, no dividers. Any register write restarts the raster
// at the first pixel; write registers only while no pixel is in flight.
module led_dot_matrix_glyph_atlas_unit #(
  parameter int GLYPH_COUNT  = ldga_pkg::GLYPH_COUNT_DEF,
  parameter int CELLS_ACROSS = ldga_pkg::CELLS_ACROSS_DEF,
  parameter int CELLS_DOWN   = ldga_pkg::CELLS_DOWN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pixel_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_pixel_on,
  output logic [ldga_pkg::POS_X_W-1:0]  out_pos_x,
  output logic [ldga_pkg::POS_Y_W-1:0]  out_pos_y,
  output logic [ldga_pkg::CODE_W-1:0]   out_cell_char,
  output logic                          out_frame_last,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ldga_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [ldga_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [ldga_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import ldga_pkg::*;

  localparam int COL_W = (CELLS_ACROSS > 1) ? $clog2(CELLS_ACROSS) : 1;
  localparam int ROW_W = (CELLS_DOWN > 1) ? $clog2(CELLS_DOWN) : 1;

  // configuration
  logic [CFG_W-1:0] dot_size_r, dot_margin_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_size_r   <= CFG_W'(1);
      dot_margin_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_DOT_MARGIN) begin
        dot_margin_r <= cfg_pwdata[CFG_W-1:0];
      end else begin
        dot_size_r <= cfg_pwdata[CFG_W-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_DOT_MARGIN) ?
                      {{(APB_DW-CFG_W){1'b0}}, dot_margin_r} :
                      {{(APB_DW-CFG_W){1'b0}}, dot_size_r};

  // geometry
  logic [CFG_W-1:0]     size_eff;
  logic [DOT_POS_W-1:0] span_m1;
  logic [IN_CELL_W-1:0] cell_w_m1, cell_h_m1;

  assign size_eff  = (dot_size_r == '0) ? CFG_W'(1) : dot_size_r;
  assign span_m1   = DOT_POS_W'(size_eff) + DOT_POS_W'(dot_margin_r) - DOT_POS_W'(1);
  assign cell_w_m1 = IN_CELL_W'(size_eff) * IN_CELL_W'(7)
                   + IN_CELL_W'(dot_margin_r) * IN_CELL_W'(4) - IN_CELL_W'(1);
  assign cell_h_m1 = IN_CELL_W'(size_eff) * IN_CELL_W'(9)
                   + IN_CELL_W'(dot_margin_r) * IN_CELL_W'(6) - IN_CELL_W'(1);

  // raster counters
  logic [POS_X_W-1:0]   x_count_r, x_count_nxt;
  logic [POS_Y_W-1:0]   y_count_r, y_count_nxt;
  logic [IN_CELL_W-1:0] x_in_cell_r, x_in_cell_nxt, y_in_cell_r, y_in_cell_nxt;
  logic [COL_W-1:0]     cell_column_r, cell_column_nxt;
  logic [ROW_W-1:0]     cell_row_r, cell_row_nxt;
  logic [DOT_POS_W-1:0] xd_pos_r, xd_pos_nxt, yd_pos_r, yd_pos_nxt;
  logic [DOT_IDX_W-1:0] xd_idx_r, xd_idx_nxt, yd_idx_r, yd_idx_nxt;

  // pipeline control
  logic s1_valid_r, out_valid_r;
  logic out_load, s1_load, accept, fire;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_load  = !s1_valid_r || out_load;
  assign in_stall = !s1_load;
  assign accept   = in_valid && s1_load;
  assign fire     = accept && in_pixel_tick;

  logic x_end, y_end, last_col, last_row;

  assign x_end    = x_in_cell_r >= cell_w_m1;
  assign y_end    = y_in_cell_r >= cell_h_m1;
  assign last_col = (cell_column_r >= COL_W'(CELLS_ACROSS - 1)) && x_end;
  assign last_row = (cell_row_r >= ROW_W'(CELLS_DOWN - 1)) && y_end;

  always_comb begin
    x_count_nxt     = x_count_r;
    y_count_nxt     = y_count_r;
    x_in_cell_nxt   = x_in_cell_r;
    y_in_cell_nxt   = y_in_cell_r;
    cell_column_nxt = cell_column_r;
    cell_row_nxt    = cell_row_r;
    xd_pos_nxt      = xd_pos_r;
    xd_idx_nxt      = xd_idx_r;
    yd_pos_nxt      = yd_pos_r;
    yd_idx_nxt      = yd_idx_r;
    if (cfg_wr) begin
      x_count_nxt     = '0;
      y_count_nxt     = '0;
      x_in_cell_nxt   = '0;
      y_in_cell_nxt   = '0;
      cell_column_nxt = '0;
      cell_row_nxt    = '0;
      xd_pos_nxt      = '0;
      xd_idx_nxt      = '0;
      yd_pos_nxt      = '0;
      yd_idx_nxt      = '0;
    end else if (fire) begin
      if (!last_col) begin
        x_count_nxt = x_count_r + POS_X_W'(1);
        if (x_end) begin
          x_in_cell_nxt   = '0;
          cell_column_nxt = cell_column_r + COL_W'(1);
          xd_pos_nxt      = '0;
          xd_idx_nxt      = '0;
        end else begin
          x_in_cell_nxt = x_in_cell_r + IN_CELL_W'(1);
          if (xd_pos_r >= span_m1) begin
            xd_pos_nxt = '0;
            xd_idx_nxt = (xd_idx_r == '1) ? xd_idx_r : xd_idx_r + DOT_IDX_W'(1);
          end else begin
            xd_pos_nxt = xd_pos_r + DOT_POS_W'(1);
          end
        end
      end else begin
        x_count_nxt     = '0;
        x_in_cell_nxt   = '0;
        cell_column_nxt = '0;
        xd_pos_nxt      = '0;
        xd_idx_nxt      = '0;
        if (last_row || y_end) begin
          y_in_cell_nxt = '0;
          yd_pos_nxt    = '0;
          yd_idx_nxt    = '0;
          if (last_row) begin
            y_count_nxt  = '0;
            cell_row_nxt = '0;
          end else begin
            y_count_nxt  = y_count_r + POS_Y_W'(1);
            cell_row_nxt = cell_row_r + ROW_W'(1);
          end
        end else begin
          y_count_nxt   = y_count_r + POS_Y_W'(1);
          y_in_cell_nxt = y_in_cell_r + IN_CELL_W'(1);
          if (yd_pos_r >= span_m1) begin
            yd_pos_nxt = '0;
            yd_idx_nxt = (yd_idx_r == '1) ? yd_idx_r : yd_idx_r + DOT_IDX_W'(1);
          end else begin
            yd_pos_nxt = yd_pos_r + DOT_POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_count_r     <= '0;
      y_count_r     <= '0;
      x_in_cell_r   <= '0;
      y_in_cell_r   <= '0;
      cell_column_r <= '0;
      cell_row_r    <= '0;
      xd_pos_r      <= '0;
      xd_idx_r      <= '0;
      yd_pos_r      <= '0;
      yd_idx_r      <= '0;
    end else begin
      x_count_r     <= x_count_nxt;
      y_count_r     <= y_count_nxt;
      x_in_cell_r   <= x_in_cell_nxt;
      y_in_cell_r   <= y_in_cell_nxt;
      cell_column_r <= cell_column_nxt;
      cell_row_r    <= cell_row_nxt;
      xd_pos_r      <= xd_pos_nxt;
      xd_idx_r      <= xd_idx_nxt;
      yd_pos_r      <= yd_pos_nxt;
      yd_idx_r      <= yd_idx_nxt;
    end
  end

  // stage 0: cell lookup and dot hit, ROM read issued
  logic [CELL_IDX_W-1:0] cell_idx, row_ext;
  logic                  cell_used, on_dot;
  logic [DOT_BIT_W-1:0]  dot_bit;

  assign row_ext   = CELL_IDX_W'(cell_row_r);
  assign cell_idx  = CELL_IDX_W'(row_ext * CELL_IDX_W'(CELLS_ACROSS))
                   + CELL_IDX_W'(cell_column_r);
  assign cell_used = cell_idx < CELL_IDX_W'(GLYPH_COUNT);
  assign on_dot    = (xd_idx_r < DOT_IDX_W'(GLYPH_COLS))
                  && (yd_idx_r < DOT_IDX_W'(GLYPH_ROWS))
                  && (xd_pos_r < DOT_POS_W'(size_eff))
                  && (yd_pos_r < DOT_POS_W'(size_eff));
  assign dot_bit   = DOT_BIT_W'(DOT_BITS - 1)
                   - (DOT_BIT_W'(yd_idx_r) * DOT_BIT_W'(GLYPH_COLS) + DOT_BIT_W'(xd_idx_r));

  glyph_t rom_data;

  ldga_glyph_rom u_rom (
    .clk     (clk),
    .rd_en   (s1_load),
    .rd_addr (cell_idx[ROM_AW-1:0]),
    .rd_data (rom_data)
  );

  // stage 1: ROM data arrives
  logic [POS_X_W-1:0]   s1_pos_x_r;
  logic [POS_Y_W-1:0]   s1_pos_y_r;
  logic                 s1_last_r, s1_used_r, s1_on_dot_r;
  logic [DOT_BIT_W-1:0] s1_dot_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pos_x_r   <= x_count_r;
      s1_pos_y_r   <= y_count_r;
      s1_last_r    <= last_col && last_row;
      s1_used_r    <= cell_used;
      s1_on_dot_r  <= on_dot;
      s1_dot_bit_r <= dot_bit;
    end
  end

  // output register
  logic                 out_pixel_on_r, out_frame_last_r;
  logic [POS_X_W-1:0]   out_pos_x_r;
  logic [POS_Y_W-1:0]   out_pos_y_r;
  logic [CODE_W-1:0]    out_cell_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel_on_r   <= s1_used_r && s1_on_dot_r && rom_data.dots[s1_dot_bit_r];
      out_pos_x_r      <= s1_pos_x_r;
      out_pos_y_r      <= s1_pos_y_r;
      out_cell_char_r  <= s1_used_r ? rom_data.code : '0;
      out_frame_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_on   = out_pixel_on_r;
  assign out_pos_x      = out_pos_x_r;
  assign out_pos_y      = out_pos_y_r;
  assign out_cell_char  = out_cell_char_r;
  assign out_frame_last = out_frame_last_r;

endmodule

>>> hw/rtl/ldga_glyph_rom.sv
// Synchronous glyph ROM: one read port, registered read data.
// Depends on ldga_pkg for the glyph table and glyph_t.
module ldga_glyph_rom (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [ldga_pkg::ROM_AW-1:0]  rd_addr,
  output ldga_pkg::glyph_t             rd_data
);
  import ldga_pkg::*;

  glyph_t rom_mem [ROM_SLOTS];
  glyph_t rd_data_r;

  always_comb begin
    for (int i = 0; i < ROM_SLOTS; i++) begin
      rom_mem[i] = glyph_entry(ROM_AW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> tb/testbench.sv
// Testbench for the LED dot-matrix glyph atlas raster generator: drives pixel
// requests in bursts under output stalls and checks every pixel against its own
// raster predictor and 5x7 font table. Depends on ldga_pkg and the unit itself.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ldga_pkg::*;

  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 2000;

  // {ascii, seven dot rows of one byte each, top row first, leftmost dot = bit 4}
  localparam logic [63:0] FONT_ROM [GLYPH_COUNT_DEF] = '{
    {"A", 56'h0E11111F111111}, {"B", 56'h1E11111E11111E}, {"C", 56'h0E11111011110E},
    {"D", 56'h1E11111111111E}, {"E", 56'h1F10101E10101F}, {"F", 56'h1F10101E101010},
    {"G", 56'h0E11111017110E}, {"H", 56'h1111111F111111}, {"I", 56'h0E04040404040E},
    {"J", 56'h0301010111110E}, {"K", 56'h11121418141211}, {"L", 56'h1010101010101F},
    {"M", 56'h111B1511111111}, {"N", 56'h11111915131111}, {"O", 56'h0E11111111110E},
    {"P", 56'h1E11111E101010}, {"Q", 56'h0E11111115130F}, {"R", 56'h1E11111E141211},
    {"S", 56'h0E11100E01110E}, {"T", 56'h1F040404040404}, {"U", 56'h1111111111110E},
    {"V", 56'h11111111110A04}, {"W", 56'h1111111115150A}, {"X", 56'h11110A040A1111},
    {"Y", 56'h11110A04040404}, {"Z", 56'h1F01020408101F}, {"0", 56'h0E11131519110E},
    {"1", 56'h040C040404040E}, {"2", 56'h0E11010204081F}, {"3", 56'h0E11010601110E},
    {"4", 56'h030509111F0101}, {"5", 56'h1F10101E01011E}, {"6", 56'h0E11101E11110E},
    {"7", 56'h1F010204040404}, {"8", 56'h0E11110E11110E}, {"9", 56'h0E11110F01110E},
    {"a", 56'h00000C1212120D}, {"b", 56'h0010101C12121C}, {"c", 56'h00000C1210120C},
    {"d", 56'h0002020E12120E}, {"e", 56'h00000C121E100E}, {"f", 56'h000C10101C1010},
    {"g", 56'h000C12120E020C}, {"h", 56'h0010101C121212}, {"i", 56'h00100010101010},
    {"j", 56'h0200020202120C}, {"k", 56'h00101214181412}, {"l", 56'h00101010101010},
    {"m", 56'h00000A15151111}, {"n", 56'h0000141A121212}, {"o", 56'h00000C1212120C},
    {"p", 56'h001C12121C1010}, {"q", 56'h000E12120E0202}, {"r", 56'h00001618101010},
    {"s", 56'h00000E100C021C}, {"t", 56'h0010101C10100C}, {"u", 56'h0000121212120C},
    {"v", 56'h00001111110A04}, {"w", 56'h0000111111150A}, {"x", 56'h0000110A040A11},
    {"y", 56'h00110A04040404}, {"z", 56'h00001F0204081F}, {".", 56'h00000000000004},
    {",", 56'h00000000000408}, {":", 56'h00000400000400}, {"-", 56'h0000001F000000},
    {"+", 56'h0004041F040400}, {"*", 56'h00000A040A0000}, {"/", 56'h01010204080810},
    {"<", 56'h00040810080400}, {">", 56'h00100804081000}, {"(", 56'h02040808080402},
    {")", 56'h08040202020408}, {"!", 56'h10101010100010}, {"?", 56'h0C120204080008},
    {" ", 56'h00000000000000}
  };

  typedef struct packed {
    logic               pixel_on;
    logic [POS_X_W-1:0] pos_x;
    logic [POS_Y_W-1:0] pos_y;
    logic [CODE_W-1:0]  cell_char;
    logic               frame_last;
  } pixel_t;

  typedef struct packed {
    logic   tick;
    logic   typed;
    pixel_t px;
  } probe_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_pixel_tick;
  logic                out_valid;
  logic                out_stall;
  logic                out_pixel_on;
  logic [POS_X_W-1:0]  out_pos_x;
  logic [POS_Y_W-1:0]  out_pos_y;
  logic [CODE_W-1:0]   out_cell_char;
  logic                out_frame_last;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [APB_AW-1:0]   cfg_paddr;
  logic [APB_DW-1:0]   cfg_pwdata;
  logic [APB_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  logic [CFG_W-1:0] geo_size = 4'd1;
  logic [CFG_W-1:0] geo_margin = 4'd0;
  int ras_x = 0, ras_y = 0, ras_xc = 0, ras_yc = 0, ras_col = 0, ras_row = 0;

  pixel_t pending_pixels [$];
  pixel_t seen_pixel;
  probe_t directed_probes [16];
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     stall_mode = 0;
  int     stall_left = 0;

  led_dot_matrix_glyph_atlas_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_tick  (in_pixel_tick),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_on   (out_pixel_on),
    .out_pos_x      (out_pos_x),
    .out_pos_y      (out_pos_y),
    .out_cell_char  (out_cell_char),
    .out_frame_last (out_frame_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // dot index along one axis, and whether the offset is on a dot rather than a gap
  function automatic logic dot_hit(input int offs, input int size, input int span,
                                   input int limit, output int idx);
    int k;
    int p;
    k = 0;
    p = offs;
    while (p >= span && k <= limit) begin
      p -= span;
      k++;
    end
    idx = k;
    return (k < limit) && (p < size);
  endfunction

  task automatic restart_raster();
    ras_x = 0;
    ras_y = 0;
    ras_xc = 0;
    ras_yc = 0;
    ras_col = 0;
    ras_row = 0;
  endtask

  task automatic raster_next_pixel(output pixel_t px);
    int size, span, cw, ch, idx, ix, iy;
    logic [63:0] g;
    logic hx, hy, lc, lr;
    size = (geo_size == 0) ? 1 : int'(geo_size);
    span = size + int'(geo_margin);
    cw = 7 * size + 4 * int'(geo_margin);
    ch = 9 * size + 6 * int'(geo_margin);
    idx = ras_row * CELLS_ACROSS_DEF + ras_col;
    px = '0;
    if (idx < GLYPH_COUNT_DEF) begin
      g = FONT_ROM[idx];
      px.cell_char = g[62:56];
      hx = dot_hit(ras_xc, size, span, GLYPH_COLS, ix);
      hy = dot_hit(ras_yc, size, span, GLYPH_ROWS, iy);
      if (hx && hy)
        px.pixel_on = g[52 - 8 * iy - ix];
    end
    lc = (ras_col >= CELLS_ACROSS_DEF - 1) && (ras_xc >= cw - 1);
    lr = (ras_row >= CELLS_DOWN_DEF - 1) && (ras_yc >= ch - 1);
    px.pos_x = ras_x[POS_X_W-1:0];
    px.pos_y = ras_y[POS_Y_W-1:0];
    px.frame_last = lc && lr;
    if (!lc) begin
      ras_x++;
      if (ras_xc >= cw - 1) begin
        ras_xc = 0;
        ras_col++;
      end else begin
        ras_xc++;
      end
    end else begin
      ras_x = 0;
      ras_xc = 0;
      ras_col = 0;
      if (lr) begin
        ras_y = 0;
        ras_yc = 0;
        ras_row = 0;
      end else begin
        ras_y++;
        if (ras_yc >= ch - 1) begin
          ras_yc = 0;
          ras_row++;
        end else begin
          ras_yc++;
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] expd,
                               input logic [31:0] got);
    if (expd !== got) begin
      $error("%s: expected %0d, got %0d", name, expd, got);
      mismatches++;
    end
  endtask

  // valid stays high after the transfer; the caller either sends again or pauses
  task automatic send_request(input logic tick, input logic typed, input pixel_t given);
    pixel_t px;
    in_valid <= 1'b1;
    in_pixel_tick <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (tick) begin
      raster_next_pixel(px);
      pending_pixels.push_back(typed ? given : px);
    end
  endtask

  task automatic pause_requests(input int cycles);
    in_valid <= 1'b0;
    in_pixel_tick <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drive_requests(input int count);
    int sent, burst;
    logic tick;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < count) begin
        tick = ($urandom_range(0, 9) != 0);
        send_request(tick, 1'b0, '0);
        if (tick) sent++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0)
        pause_requests($urandom_range(1, 12));
    end
  endtask

  task automatic write_reg(input logic reg_idx, input logic [CFG_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= {28'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_idx == REG_DOT_SIZE)
      geo_size = value;
    else
      geo_margin = value;
    restart_raster();
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] size, input logic [CFG_W-1:0] margin);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_DOT_SIZE, size);
    @(posedge clk);
    write_reg(REG_DOT_MARGIN, margin);
  endtask

  // receiver: stall pattern switches at random between four modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(4, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      2: out_stall <= ~out_stall;
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel transfer with nothing expected: x=%0d y=%0d", out_pos_x, out_pos_y);
        mismatches++;
      end else begin
        seen_pixel = pending_pixels.pop_front();
        compare_field("pixel_on", seen_pixel.pixel_on, out_pixel_on);
        compare_field("pos_x", seen_pixel.pos_x, out_pos_x);
        compare_field("pos_y", seen_pixel.pos_y, out_pos_y);
        compare_field("cell_char", seen_pixel.cell_char, out_cell_char);
        compare_field("frame_last", seen_pixel.frame_last, out_frame_last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pixel_tick <= 1'b0;
    out_stall <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    // reset geometry: 7x9 cells, 'A' then 'B' along the top row
    directed_probes = '{
      '{1'b1, 1'b1, '{1'b0, 11'd0, 12'd0, 7'h41, 1'b0}},
      '{1'b0, 1'b0, '0},
      '{1'b1, 1'b1, '{1'b1, 11'd1, 12'd0, 7'h41, 1'b0}},
      '{1'b1, 1'b1, '{1'b1, 11'd2, 12'd0, 7'h41, 1'b0}},
      '{1'b1, 1'b1, '{1'b1, 11'd3, 12'd0, 7'h41, 1'b0}},
      '{1'b1, 1'b1, '{1'b0, 11'd4, 12'd0, 7'h41, 1'b0}},
      '{1'b0, 1'b0, '0},
      '{1'b1, 1'b1, '{1'b0, 11'd5, 12'd0, 7'h41, 1'b0}},
      '{1'b1, 1'b1, '{1'b0, 11'd6, 12'd0, 7'h41, 1'b0}},
      '{1'b1, 1'b1, '{1'b1, 11'd7, 12'd0, 7'h42, 1'b0}},
      '{1'b1, 1'b1, '{1'b1, 11'd8, 12'd0, 7'h42, 1'b0}},
      '{1'b1, 1'b0, '0},
      '{1'b1, 1'b0, '0},
      '{1'b0, 1'b0, '0},
      '{1'b1, 1'b0, '0},
      '{1'b1, 1'b0, '0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_probes[i]) begin
      send_request(directed_probes[i].tick, directed_probes[i].typed, directed_probes[i].px);
      if ($urandom_range(0, 2) == 0)
        pause_requests($urandom_range(1, 3));
    end

    // smallest geometry, zero size, widest dots and gaps, then random settings
    set_geometry(4'd1, 4'd0);
    drive_requests(450);
    set_geometry(4'd0, 4'd3);
    drive_requests(200);
    set_geometry(4'd15, 4'd15);
    drive_requests(250);
    set_geometry(4'd1, 4'd15);
    drive_requests(200);
    set_geometry(4'd15, 4'd0);
    drive_requests(150);
    repeat (4) begin
      set_geometry(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
      drive_requests(50);
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
